@@ sv/kgeg_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Kautz graph edge generator package
// Shared codes, field widths, parameter defaults and the walker status type.
// ----------------------------------------------------------------------------
package kgeg_pkg;

    localparam int DEF_MAX_LETTER  = 7;
    localparam int DEF_MAX_SUFFIX  = 3;
    localparam int DEF_TABLE_DEPTH = 4096;

    localparam int VTX_W  = 12;
    localparam int CNT_W  = 13;
    localparam int KIND_W = 2;
    localparam int CFGM_W = 3;
    localparam int CFGN_W = 2;

    localparam logic OP_BUILD = 1'b0;
    localparam logic OP_EDGE  = 1'b1;

    localparam logic [KIND_W-1:0] KIND_BUILD = 2'd0;
    localparam logic [KIND_W-1:0] KIND_EDGE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RANGE = 2'd2;

    localparam logic REG_ALPHABET = 1'b0;
    localparam logic REG_SUFFIX   = 1'b1;

    typedef struct packed {
        logic busy;
        logic done;
    } t_walk_stat;

endpackage

@@ sv/kgeg_tables.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Kautz graph vertex tables
// String-to-rank and rank-to-string memories, one write and one registered
// read port each. Builds and queries never overlap.
// ----------------------------------------------------------------------------
module kgeg_tables
    import kgeg_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int AW = 12,
    parameter int CW = 13,
    parameter int RW = 15
) (
    input  logic          i_clk,
    input  logic          i_s2r_we,
    input  logic [AW-1:0] i_s2r_waddr,
    input  logic [CW-1:0] i_s2r_wdata,
    input  logic          i_s2r_re,
    input  logic [AW-1:0] i_s2r_raddr,
    output logic [CW-1:0] o_s2r_rdata,
    input  logic          i_r2s_we,
    input  logic [AW-1:0] i_r2s_waddr,
    input  logic [RW-1:0] i_r2s_wdata,
    input  logic          i_r2s_re,
    input  logic [AW-1:0] i_r2s_raddr,
    output logic [RW-1:0] o_r2s_rdata
);

    logic [CW-1:0] r_s2r_mem [0:TABLE_DEPTH-1];
    logic [RW-1:0] r_r2s_mem [0:TABLE_DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (i_s2r_we) begin
            r_s2r_mem[i_s2r_waddr] <= i_s2r_wdata;
        end
        if (i_s2r_re) begin
            o_s2r_rdata <= r_s2r_mem[i_s2r_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_r2s_we) begin
            r_r2s_mem[i_r2s_waddr] <= i_r2s_wdata;
        end
        if (i_r2s_re) begin
            o_r2s_rdata <= r_r2s_mem[i_r2s_raddr];
        end
    end

endmodule

@@ sv/kgeg_walker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Kautz graph build walker
// Sizes the string space; if it fits, steps an odometer over every value,
// one per cycle, writing ranks and per-vertex successor basis/last letter.
// ----------------------------------------------------------------------------
module kgeg_walker
    import kgeg_pkg::*;
#(
    parameter int MAX_SUFFIX  = DEF_MAX_SUFFIX,
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int DW = 3,
    parameter int NW = 2,
    parameter int AW = 12,
    parameter int CW = 13,
    parameter int PW = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DW-1:0]    i_m,
    input  logic [NW-1:0]    i_n,
    output t_walk_stat       o_stat,
    output logic [CW-1:0]    o_count,
    output logic             o_s2r_we,
    output logic [AW-1:0]    o_s2r_addr,
    output logic [CW-1:0]    o_s2r_data,
    output logic             o_r2s_we,
    output logic [AW-1:0]    o_r2s_addr,
    output logic [DW+AW-1:0] o_r2s_data
);

    localparam logic [1:0] W_IDLE = 2'd0;
    localparam logic [1:0] W_POW  = 2'd1;
    localparam logic [1:0] W_WALK = 2'd2;
    localparam logic [1:0] W_DONE = 2'd3;

    logic [1:0]    r_st;
    logic [PW-1:0] r_pow;
    logic [NW-1:0] r_k;
    logic [DW-1:0] r_dig [0:MAX_SUFFIX];
    logic [AW-1:0] r_v;
    logic [AW-1:0] r_basis;
    logic [CW-1:0] r_rank;
    logic [CW-1:0] r_count;

    logic [DW:0]   w_radix;
    logic [PW-1:0] w_prod;
    logic [PW-1:0] n_pow;
    logic          w_ok;
    logic          w_cin_top;
    logic          w_cout;
    logic [DW-1:0] n_dig [0:MAX_SUFFIX];
    logic [AW-1:0] n_basis;

    assign w_radix = {1'b0, i_m} + 1'b1;
    assign w_prod  = r_pow * PW'(w_radix);
    assign n_pow   = (w_prod > PW'(TABLE_DEPTH)) ? PW'(TABLE_DEPTH + 1) : w_prod;

    always_comb begin
        logic c;
        w_ok = 1'b1;
        for (int k = 1; k <= MAX_SUFFIX; k++) begin
            if (k <= int'(i_n) && r_dig[k] == r_dig[k-1]) begin
                w_ok = 1'b0;
            end
        end
        c = 1'b1;
        w_cin_top = 1'b0;
        w_cout = 1'b0;
        for (int k = 0; k <= MAX_SUFFIX; k++) begin
            n_dig[k] = r_dig[k];
            if (k == int'(i_n)) begin
                w_cin_top = c;
            end
            if (k <= int'(i_n) && c) begin
                if (r_dig[k] == i_m) begin
                    n_dig[k] = '0;
                end else begin
                    n_dig[k] = r_dig[k] + 1'b1;
                    c = 1'b0;
                end
            end
            if (k == int'(i_n)) begin
                w_cout = c;
            end
        end
        n_basis = w_cin_top ? '0 : r_basis + AW'(w_radix);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= W_IDLE;
            for (int k = 0; k <= MAX_SUFFIX; k++) begin
                r_dig[k] <= '0;
            end
        end else begin
            unique case (r_st)
                W_IDLE: begin
                    if (i_start) begin
                        r_pow <= PW'(1);
                        r_k   <= '0;
                        r_st  <= W_POW;
                    end
                end
                W_POW: begin
                    r_pow <= n_pow;
                    r_k   <= r_k + 1'b1;
                    if (r_k == i_n) begin
                        if (n_pow > PW'(TABLE_DEPTH)) begin
                            r_count <= '0;
                            r_st    <= W_DONE;
                        end else begin
                            for (int k = 0; k <= MAX_SUFFIX; k++) begin
                                r_dig[k] <= '0;
                            end
                            r_v     <= '0;
                            r_basis <= '0;
                            r_rank  <= '0;
                            r_st    <= W_WALK;
                        end
                    end
                end
                W_WALK: begin
                    r_dig   <= n_dig;
                    r_v     <= r_v + 1'b1;
                    r_basis <= n_basis;
                    r_rank  <= r_rank + CW'(w_ok);
                    if (w_cout) begin
                        r_count <= r_rank + CW'(w_ok);
                        r_st    <= W_DONE;
                    end
                end
                W_DONE: begin
                    r_st <= W_IDLE;
                end
                default: begin
                    r_st <= W_IDLE;
                end
            endcase
        end
    end

    assign o_stat.busy = (r_st != W_IDLE);
    assign o_stat.done = (r_st == W_DONE);
    assign o_count     = r_count;

    assign o_s2r_we   = (r_st == W_WALK);
    assign o_s2r_addr = r_v;
    assign o_s2r_data = w_ok ? r_rank + 1'b1 : '0;
    assign o_r2s_we   = (r_st == W_WALK) && w_ok;
    assign o_r2s_addr = r_rank[AW-1:0];
    assign o_r2s_data = {r_dig[0], r_basis};

endmodule

@@ sv/kautz_graph_edge_generator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Kautz graph edge generator
// Build: after acceptance, a start pulse, sizing of the string space, a walk over
//   every string value if it fits the table, then done and the reply load.
// Edge query: the vertex entry is read, then each letter is issued in turn,
//   with one output load per edge; range errors reply without a table read.
// One command at a time; a stalled output holds the sequencer.
// Synchronous active-low reset: m=1, n=1, no vertices; tables are not cleared.
// ----------------------------------------------------------------------------
module kautz_graph_edge_generator
    import kgeg_pkg::*;
#(
    parameter int MAX_LETTER  = DEF_MAX_LETTER,
    parameter int MAX_SUFFIX  = DEF_MAX_SUFFIX,
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,   // [11:0] vertex, rest zero
    input  logic [0:0]  i_s_axis_tuser,   // [0] opcode
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,   // [11:0] from_vertex, [23:12] to_vertex,
                                          // [36:24] vertex_count, rest zero
    output logic [1:0]  o_m_axis_tuser,   // [1:0] kind
    output logic        o_m_axis_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [0:0]  i_cfg_index,
    input  logic [2:0]  i_cfg_data
);

    localparam int DW = $clog2(MAX_LETTER + 1);
    localparam int NW = (MAX_SUFFIX > 0) ? $clog2(MAX_SUFFIX + 1) : 1;
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int RW = DW + AW;
    localparam int PW = $clog2((TABLE_DEPTH + 1) * (MAX_LETTER + 1) + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_BUILD = 3'd1;
    localparam logic [2:0] S_BREP  = 3'd2;
    localparam logic [2:0] S_ERR   = 3'd3;
    localparam logic [2:0] S_ERD   = 3'd4;
    localparam logic [2:0] S_ISSUE = 3'd5;
    localparam logic [2:0] S_DATA  = 3'd6;

    logic [2:0]        r_state;
    logic [CFGM_W-1:0] r_cfg_m;
    logic [CFGN_W-1:0] r_cfg_n;
    logic [DW-1:0]     r_built_m;
    logic [NW-1:0]     r_built_n;
    logic [CW-1:0]     r_node_total;
    logic [VTX_W-1:0]  r_vtx;
    logic [DW-1:0]     r_last_l;
    logic [AW-1:0]     r_basis;
    logic [DW-1:0]     r_j;
    logic              r_start;

    logic              r_out_valid;
    logic [KIND_W-1:0] r_out_kind;
    logic [VTX_W-1:0]  r_out_from;
    logic [VTX_W-1:0]  r_out_to;
    logic [CNT_W-1:0]  r_out_cnt;
    logic              r_out_last;

    logic [DW-1:0]     w_m_cl;
    logic [NW-1:0]     w_n_cl;
    logic              w_in_acc;
    logic              w_out_free;
    logic              w_range_err;
    logic              w_more;
    logic [VTX_W-1:0]  w_in_vtx;
    logic              w_in_op;

    t_walk_stat        w_stat;
    logic [CW-1:0]     w_count;
    logic              w_s2r_we;
    logic [AW-1:0]     w_s2r_waddr;
    logic [CW-1:0]     w_s2r_wdata;
    logic              w_r2s_we;
    logic [AW-1:0]     w_r2s_waddr;
    logic [RW-1:0]     w_r2s_wdata;
    logic              w_s2r_re;
    logic [AW-1:0]     w_s2r_raddr;
    logic [CW-1:0]     w_s2r_rdata;
    logic              w_r2s_re;
    logic [AW-1:0]     w_r2s_raddr;
    logic [RW-1:0]     w_r2s_rdata;

    assign w_m_cl = (int'(r_cfg_m) > MAX_LETTER) ? DW'(MAX_LETTER) : DW'(r_cfg_m);
    assign w_n_cl = (int'(r_cfg_n) > MAX_SUFFIX) ? NW'(MAX_SUFFIX) : NW'(r_cfg_n);

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_in_acc        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_in_vtx        = i_s_axis_tdata[VTX_W-1:0];
    assign w_in_op         = i_s_axis_tuser[0];
    assign w_out_free      = !r_out_valid || i_m_axis_tready;
    assign w_range_err     = (32'(w_in_vtx) >= 32'(r_node_total))
                          || (32'(w_in_vtx) >= TABLE_DEPTH);
    assign w_more = (r_j < r_built_m)
                 && !((({1'b0, r_j} + 1'b1) == {1'b0, r_built_m})
                      && (r_last_l == r_built_m));

    assign w_r2s_re    = w_in_acc && (w_in_op == OP_EDGE) && !w_range_err;
    assign w_r2s_raddr = AW'(w_in_vtx);
    assign w_s2r_re    = (r_state == S_ISSUE) && (r_j != r_last_l);
    assign w_s2r_raddr = r_basis + AW'(r_j);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_m <= CFGM_W'(1);
            r_cfg_n <= CFGN_W'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index[0])
                REG_ALPHABET: r_cfg_m <= i_cfg_data[CFGM_W-1:0];
                REG_SUFFIX:   r_cfg_n <= i_cfg_data[CFGN_W-1:0];
                default:      r_cfg_m <= r_cfg_m;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_built_m    <= '0;
            r_built_n    <= '0;
            r_node_total <= '0;
            r_start      <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_start <= 1'b0;
            if (r_out_valid && i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_vtx <= w_in_vtx;
                        unique case (w_in_op)
                            OP_BUILD: begin
                                r_built_m <= w_m_cl;
                                r_built_n <= w_n_cl;
                                r_start   <= 1'b1;
                                r_state   <= S_BUILD;
                            end
                            OP_EDGE: begin
                                r_state <= w_range_err ? S_ERR : S_ERD;
                            end
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                S_BUILD: begin
                    if (w_stat.done) begin
                        r_node_total <= w_count;
                        r_state      <= S_BREP;
                    end
                end
                S_BREP: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_kind  <= KIND_BUILD;
                        r_out_from  <= '0;
                        r_out_to    <= '0;
                        r_out_cnt   <= CNT_W'(r_node_total);
                        r_out_last  <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                S_ERR: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_kind  <= KIND_RANGE;
                        r_out_from  <= r_vtx;
                        r_out_to    <= '0;
                        r_out_cnt   <= '0;
                        r_out_last  <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                S_ERD: begin
                    r_last_l <= w_r2s_rdata[RW-1:AW];
                    r_basis  <= w_r2s_rdata[AW-1:0];
                    r_j      <= '0;
                    r_state  <= S_ISSUE;
                end
                S_ISSUE: begin
                    if (r_j != r_last_l) begin
                        r_state <= S_DATA;
                    end else if (r_j == r_built_m) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_j <= r_j + 1'b1;
                    end
                end
                S_DATA: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_kind  <= KIND_EDGE;
                        r_out_from  <= r_vtx;
                        r_out_to    <= VTX_W'(w_s2r_rdata - 1'b1);
                        r_out_cnt   <= '0;
                        r_out_last  <= !w_more;
                        if (r_j == r_built_m) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_j     <= r_j + 1'b1;
                            r_state <= S_ISSUE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {3'b000, r_out_cnt, r_out_to, r_out_from};
    assign o_m_axis_tuser  = r_out_kind;
    assign o_m_axis_tlast  = r_out_last;

    kgeg_walker #(
        .MAX_SUFFIX  (MAX_SUFFIX),
        .TABLE_DEPTH (TABLE_DEPTH),
        .DW          (DW),
        .NW          (NW),
        .AW          (AW),
        .CW          (CW),
        .PW          (PW)
    ) u_walker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_start),
        .i_m        (r_built_m),
        .i_n        (r_built_n),
        .o_stat     (w_stat),
        .o_count    (w_count),
        .o_s2r_we   (w_s2r_we),
        .o_s2r_addr (w_s2r_waddr),
        .o_s2r_data (w_s2r_wdata),
        .o_r2s_we   (w_r2s_we),
        .o_r2s_addr (w_r2s_waddr),
        .o_r2s_data (w_r2s_wdata)
    );

    kgeg_tables #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .AW          (AW),
        .CW          (CW),
        .RW          (RW)
    ) u_tables (
        .i_clk       (i_clk),
        .i_s2r_we    (w_s2r_we),
        .i_s2r_waddr (w_s2r_waddr),
        .i_s2r_wdata (w_s2r_wdata),
        .i_s2r_re    (w_s2r_re),
        .i_s2r_raddr (w_s2r_raddr),
        .o_s2r_rdata (w_s2r_rdata),
        .i_r2s_we    (w_r2s_we),
        .i_r2s_waddr (w_r2s_waddr),
        .i_r2s_wdata (w_r2s_wdata),
        .i_r2s_re    (w_r2s_re),
        .i_r2s_raddr (w_r2s_raddr),
        .o_r2s_rdata (w_r2s_rdata)
    );

    a_walk_only_in_build: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.busy |-> (r_state == S_BUILD || r_start))
        else $error("walker active outside a build");

    a_done_in_build: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.done |-> (r_state == S_BUILD))
        else $error("walk finished while not building");

    a_no_read_while_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s2r_re || w_r2s_re) |-> !w_stat.busy)
        else $error("table read during build");

    a_edge_target_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) && (r_out_kind == KIND_EDGE)
            |-> (32'(r_out_to) < 32'(r_node_total)))
        else $error("edge target beyond vertex count");

endmodule
